### sv/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) `ASSERT_CLK(lbl, !(expr))
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

### sv/c8x_pkg.sv
// Shared types and constants for the instruction execute block.
// No dependencies.
package c8x_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int STACK_DEPTH   = 16;
    localparam int MEM_DEPTH     = 4096;

    localparam int X_BITS   = $clog2(SCREEN_WIDTH);
    localparam int Y_BITS   = $clog2(SCREEN_HEIGHT);
    localparam int SP_BITS  = $clog2(STACK_DEPTH);
    localparam int MA_BITS  = $clog2(MEM_DEPTH);
    localparam int LVL_BITS = $clog2(STACK_DEPTH + 1);

    localparam logic [11:0] FONT_BASE_RST     = 12'd80;
    localparam logic [11:0] START_ADDRESS_RST = 12'd512;
    localparam logic [7:0]  GLYPH_BYTES       = 8'd5;

    localparam logic [1:0] CFG_FONT_BASE = 2'd0;

    localparam logic [1:0] REQ_EXEC   = 2'd0;
    localparam logic [1:0] REQ_MEM_WR = 2'd1;
    localparam logic [1:0] REQ_MEM_RD = 2'd2;
    localparam logic [1:0] REQ_ROW_RD = 2'd3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNSUP = 2'd1,
        ST_OVF   = 2'd2,
        ST_UNF   = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_CLS, OP_RET, OP_JP, OP_CALL, OP_SE, OP_SNE, OP_SEV, OP_SNEV,
        OP_LD, OP_ADD, OP_ALU, OP_LDI, OP_DRW, OP_GETDT, OP_SETDT,
        OP_SETST, OP_FONT, OP_STORE, OP_LOAD, OP_BAD, OP_MWR, OP_MRD, OP_ROW
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE, S_RDX, S_RDY, S_EXEC, S_WRF, S_DREQ, S_DDAT,
        S_SRD, S_SWR, S_LRD, S_LWR, S_MRD, S_ROW, S_DONE
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] instr;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [4:0]  row_select;
    } item_t;

    typedef struct packed {
        logic [11:0]             pc;
        logic [15:0]             index;
        logic [7:0]              flag;
        status_t                 status;
        logic [7:0]              read_byte;
        logic [SCREEN_WIDTH-1:0] frame_row;
    } result_t;

endpackage

### sv/c8x_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module c8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/c8x_front.sv
// Front end: accepts requests, decodes them and holds them in a two-entry queue.
// Depends on c8x_pkg.
module c8x_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       req_type,
    input  logic [15:0]      instr,
    input  logic [11:0]      mem_addr,
    input  logic [7:0]       mem_data,
    input  logic [4:0]       row_select,
    output logic             q_valid,
    output c8x_pkg::item_t   q_item,
    input  logic             q_pop
);
    c8x_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    c8x_pkg::op_t   op;
    logic           do_push;

    always_comb
    begin
        op = c8x_pkg::OP_BAD;
        unique case (req_type)
            c8x_pkg::REQ_MEM_WR: op = c8x_pkg::OP_MWR;
            c8x_pkg::REQ_MEM_RD: op = c8x_pkg::OP_MRD;
            c8x_pkg::REQ_ROW_RD: op = c8x_pkg::OP_ROW;
            default:
            begin
                unique case (instr[15:12])
                    4'h0:
                    begin
                        if (instr == 16'h00E0)
                        begin
                            op = c8x_pkg::OP_CLS;
                        end
                        else if (instr == 16'h00EE)
                        begin
                            op = c8x_pkg::OP_RET;
                        end
                    end
                    4'h1: op = c8x_pkg::OP_JP;
                    4'h2: op = c8x_pkg::OP_CALL;
                    4'h3: op = c8x_pkg::OP_SE;
                    4'h4: op = c8x_pkg::OP_SNE;
                    4'h5: op = (instr[3:0] == 4'h0) ? c8x_pkg::OP_SEV : c8x_pkg::OP_BAD;
                    4'h6: op = c8x_pkg::OP_LD;
                    4'h7: op = c8x_pkg::OP_ADD;
                    4'h8:
                    begin
                        if (instr[3:0] <= 4'h5 || instr[3:0] == 4'h7)
                        begin
                            op = c8x_pkg::OP_ALU;
                        end
                    end
                    4'h9: op = (instr[3:0] == 4'h0) ? c8x_pkg::OP_SNEV : c8x_pkg::OP_BAD;
                    4'hA: op = c8x_pkg::OP_LDI;
                    4'hD: op = c8x_pkg::OP_DRW;
                    4'hF:
                    begin
                        unique case (instr[7:0])
                            8'h07:   op = c8x_pkg::OP_GETDT;
                            8'h15:   op = c8x_pkg::OP_SETDT;
                            8'h18:   op = c8x_pkg::OP_SETST;
                            8'h29:   op = c8x_pkg::OP_FONT;
                            8'h55:   op = c8x_pkg::OP_STORE;
                            8'h65:   op = c8x_pkg::OP_LOAD;
                            default: op = c8x_pkg::OP_BAD;
                        endcase
                    end
                    default: op = c8x_pkg::OP_BAD;
                endcase
            end
        endcase
    end

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        count_next  = count_reg + {1'b0, do_push} - {1'b0, q_pop && q_valid};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= '{op: op, instr: instr, mem_addr: mem_addr,
                                      mem_data: mem_data, row_select: row_select};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

### sv/c8x_back.sv
// Back end: sequencer that carries out decoded requests and holds the result.
// Depends on c8x_pkg, c8x_ram and assert_macros.svh.
`include "assert_macros.svh"
module c8x_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  c8x_pkg::item_t   q_item,
    output logic             q_pop,
    input  logic [11:0]      font_base,
    output logic             out_valid,
    output c8x_pkg::result_t out_res,
    input  logic             pop
);
    localparam int W = c8x_pkg::SCREEN_WIDTH;
    localparam int H = c8x_pkg::SCREEN_HEIGHT;

    c8x_pkg::state_t  state_reg, state_next;
    c8x_pkg::item_t   item_reg, item_next;
    c8x_pkg::status_t st_reg, st_next;
    logic [7:0]  vx_reg, vx_next, vy_reg, vy_next, flag_reg, flag_next;
    logic [11:0] pc_reg, pc_next;
    logic [15:0] index_reg, index_next;
    logic [c8x_pkg::LVL_BITS-1:0] level_reg, level_next;
    logic [11:0] stack_reg [c8x_pkg::STACK_DEPTH];
    logic        stack_we;
    logic [7:0]  delay_reg, delay_next, sound_reg, sound_next, vf_reg, vf_next;
    logic [15:0] vvalid_reg, vvalid_next;
    logic [H-1:0] fvalid_reg, fvalid_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        hit_reg, hit_next;
    logic [7:0]  rb_reg, rb_next;
    logic [W-1:0] row_reg, row_next;
    logic [3:0]  v_rq_reg;
    logic [c8x_pkg::Y_BITS-1:0] f_rq_reg;
    logic        out_valid_reg, out_valid_next;
    c8x_pkg::result_t out_reg;
    logic        res_load;

    logic        v_we;
    logic [3:0]  v_waddr, v_raddr;
    logic [7:0]  v_wdata, v_rdata, v_rd;
    logic        m_we;
    logic [c8x_pkg::MA_BITS-1:0] m_waddr, m_raddr;
    logic [7:0]  m_wdata, m_rdata;
    logic        f_we;
    logic [c8x_pkg::Y_BITS-1:0] f_waddr, f_raddr;
    logic [W-1:0] f_wdata, f_rdata, f_rd, spr_mask;
    logic [c8x_pkg::Y_BITS:0] draw_y;
    logic [8:0]  sum9;
    logic [7:0]  alu_res, alu_flag;
    logic        alu_has_flag;
    logic [c8x_pkg::MA_BITS-1:0] i_plus_k;

    c8x_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );
    c8x_ram #(.WIDTH(8), .DEPTH(c8x_pkg::MEM_DEPTH)) u_mem (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata)
    );
    c8x_ram #(.WIDTH(W), .DEPTH(H)) u_frame (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    assign v_rd     = vvalid_reg[v_rq_reg] ? v_rdata : 8'h00;
    assign f_rd     = fvalid_reg[f_rq_reg] ? f_rdata : '0;
    assign spr_mask = {m_rdata, {(W - 8){1'b0}}} >> vx_reg[c8x_pkg::X_BITS-1:0];
    assign draw_y   = {1'b0, vy_reg[c8x_pkg::Y_BITS-1:0]}
                      + (c8x_pkg::Y_BITS + 1)'(cnt_reg);
    assign i_plus_k = index_reg[c8x_pkg::MA_BITS-1:0] + c8x_pkg::MA_BITS'(cnt_reg);
    assign sum9     = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign res_load = (state_reg == c8x_pkg::S_DONE) && (!out_valid_reg || pop);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        alu_has_flag = 1'b0;
        alu_flag     = 8'h00;
        case (item_reg.instr[3:0])
            4'h0: alu_res = vy_reg;
            4'h1: alu_res = vx_reg | vy_reg;
            4'h2: alu_res = vx_reg & vy_reg;
            4'h3: alu_res = vx_reg ^ vy_reg;
            4'h4:
            begin
                alu_res      = sum9[7:0];
                alu_flag     = {7'd0, sum9[8]};
                alu_has_flag = 1'b1;
            end
            4'h5:
            begin
                alu_res      = vx_reg - vy_reg;
                alu_flag     = {7'd0, vx_reg >= vy_reg};
                alu_has_flag = 1'b1;
            end
            default:
            begin
                alu_res      = vy_reg - vx_reg;
                alu_flag     = {7'd0, vy_reg >= vx_reg};
                alu_has_flag = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        st_next        = st_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        flag_next      = flag_reg;
        pc_next        = pc_reg;
        index_next     = index_reg;
        level_next     = level_reg;
        stack_we       = 1'b0;
        delay_next     = delay_reg;
        sound_next     = sound_reg;
        vvalid_next    = vvalid_reg;
        fvalid_next    = fvalid_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        rb_next        = rb_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        v_we           = 1'b0;
        v_waddr        = item_reg.instr[11:8];
        v_wdata        = 8'h00;
        v_raddr        = item_reg.instr[11:8];
        m_we           = 1'b0;
        m_waddr        = i_plus_k;
        m_wdata        = v_rd;
        m_raddr        = i_plus_k;
        f_we           = 1'b0;
        f_waddr        = draw_y[c8x_pkg::Y_BITS-1:0];
        f_wdata        = f_rd ^ spr_mask;
        f_raddr        = draw_y[c8x_pkg::Y_BITS-1:0];

        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            c8x_pkg::S_IDLE:
            begin
                v_raddr = q_item.instr[11:8];
                m_raddr = q_item.mem_addr[c8x_pkg::MA_BITS-1:0];
                f_raddr = q_item.row_select[c8x_pkg::Y_BITS-1:0];
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    st_next   = c8x_pkg::ST_OK;
                    rb_next   = 8'h00;
                    row_next  = '0;
                    cnt_next  = 4'd0;
                    hit_next  = 1'b0;
                    case (q_item.op)
                        c8x_pkg::OP_MWR:
                        begin
                            m_we       = 1'b1;
                            m_waddr    = q_item.mem_addr[c8x_pkg::MA_BITS-1:0];
                            m_wdata    = q_item.mem_data;
                            state_next = c8x_pkg::S_DONE;
                        end
                        c8x_pkg::OP_MRD: state_next = c8x_pkg::S_MRD;
                        c8x_pkg::OP_ROW: state_next = c8x_pkg::S_ROW;
                        default:
                        begin
                            pc_next    = pc_reg + 12'd2;
                            state_next = c8x_pkg::S_RDX;
                        end
                    endcase
                end
            end
            c8x_pkg::S_MRD:
            begin
                rb_next    = m_rdata;
                state_next = c8x_pkg::S_DONE;
            end
            c8x_pkg::S_ROW:
            begin
                row_next   = f_rd;
                state_next = c8x_pkg::S_DONE;
            end
            c8x_pkg::S_RDX:
            begin
                vx_next    = v_rd;
                v_raddr    = item_reg.instr[7:4];
                state_next = c8x_pkg::S_RDY;
            end
            c8x_pkg::S_RDY:
            begin
                vy_next    = v_rd;
                state_next = c8x_pkg::S_EXEC;
            end
            c8x_pkg::S_EXEC:
            begin
                state_next = c8x_pkg::S_DONE;
                case (item_reg.op)
                    c8x_pkg::OP_CLS: fvalid_next = '0;
                    c8x_pkg::OP_RET:
                    begin
                        if (level_reg == '0)
                        begin
                            st_next = c8x_pkg::ST_UNF;
                        end
                        else
                        begin
                            level_next = level_reg - 1'b1;
                            pc_next    = stack_reg[level_next[c8x_pkg::SP_BITS-1:0]];
                        end
                    end
                    c8x_pkg::OP_JP: pc_next = item_reg.instr[11:0];
                    c8x_pkg::OP_CALL:
                    begin
                        if (level_reg == c8x_pkg::LVL_BITS'(c8x_pkg::STACK_DEPTH))
                        begin
                            st_next = c8x_pkg::ST_OVF;
                        end
                        else
                        begin
                            stack_we   = 1'b1;
                            level_next = level_reg + 1'b1;
                            pc_next    = item_reg.instr[11:0];
                        end
                    end
                    c8x_pkg::OP_SE:
                        if (vx_reg == item_reg.instr[7:0]) pc_next = pc_reg + 12'd2;
                    c8x_pkg::OP_SNE:
                        if (vx_reg != item_reg.instr[7:0]) pc_next = pc_reg + 12'd2;
                    c8x_pkg::OP_SEV:
                        if (vx_reg == vy_reg) pc_next = pc_reg + 12'd2;
                    c8x_pkg::OP_SNEV:
                        if (vx_reg != vy_reg) pc_next = pc_reg + 12'd2;
                    c8x_pkg::OP_LD:
                    begin
                        v_we    = 1'b1;
                        v_wdata = item_reg.instr[7:0];
                    end
                    c8x_pkg::OP_ADD:
                    begin
                        v_we    = 1'b1;
                        v_wdata = vx_reg + item_reg.instr[7:0];
                    end
                    c8x_pkg::OP_ALU:
                    begin
                        v_we      = 1'b1;
                        v_wdata   = alu_res;
                        flag_next = alu_flag;
                        if (alu_has_flag)
                        begin
                            state_next = c8x_pkg::S_WRF;
                        end
                    end
                    c8x_pkg::OP_LDI: index_next = {4'h0, item_reg.instr[11:0]};
                    c8x_pkg::OP_DRW: state_next = c8x_pkg::S_DREQ;
                    c8x_pkg::OP_GETDT:
                    begin
                        v_we    = 1'b1;
                        v_wdata = delay_reg;
                    end
                    c8x_pkg::OP_SETDT: delay_next = vx_reg;
                    c8x_pkg::OP_SETST: sound_next = vx_reg;
                    c8x_pkg::OP_FONT:
                        index_next = {4'h0, font_base}
                                     + 16'(vx_reg[3:0] * c8x_pkg::GLYPH_BYTES);
                    c8x_pkg::OP_STORE: state_next = c8x_pkg::S_SRD;
                    c8x_pkg::OP_LOAD:  state_next = c8x_pkg::S_LRD;
                    default: st_next = c8x_pkg::ST_UNSUP;
                endcase
            end
            c8x_pkg::S_WRF:
            begin
                v_we       = 1'b1;
                v_waddr    = 4'hF;
                v_wdata    = flag_reg;
                state_next = c8x_pkg::S_DONE;
            end
            c8x_pkg::S_DREQ:
            begin
                if (cnt_reg == item_reg.instr[3:0]
                    || draw_y >= (c8x_pkg::Y_BITS + 1)'(H))
                begin
                    v_we       = 1'b1;
                    v_waddr    = 4'hF;
                    v_wdata    = {7'd0, hit_reg};
                    state_next = c8x_pkg::S_DONE;
                end
                else
                begin
                    state_next = c8x_pkg::S_DDAT;
                end
            end
            c8x_pkg::S_DDAT:
            begin
                f_we = 1'b1;
                fvalid_next[draw_y[c8x_pkg::Y_BITS-1:0]] = 1'b1;
                hit_next   = hit_reg | (|(f_rd & spr_mask));
                cnt_next   = cnt_reg + 4'd1;
                state_next = c8x_pkg::S_DREQ;
            end
            c8x_pkg::S_SRD:
            begin
                v_raddr    = cnt_reg;
                state_next = c8x_pkg::S_SWR;
            end
            c8x_pkg::S_SWR:
            begin
                m_we = 1'b1;
                if (cnt_reg == item_reg.instr[11:8])
                begin
                    state_next = c8x_pkg::S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = c8x_pkg::S_SRD;
                end
            end
            c8x_pkg::S_LRD: state_next = c8x_pkg::S_LWR;
            c8x_pkg::S_LWR:
            begin
                v_we    = 1'b1;
                v_waddr = cnt_reg;
                v_wdata = m_rdata;
                if (cnt_reg == item_reg.instr[11:8])
                begin
                    state_next = c8x_pkg::S_DONE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = c8x_pkg::S_LRD;
                end
            end
            c8x_pkg::S_DONE:
            begin
                if (res_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = c8x_pkg::S_IDLE;
                end
            end
            default: state_next = c8x_pkg::S_IDLE;
        endcase

        vf_next = vf_reg;
        if (v_we)
        begin
            vvalid_next[v_waddr] = 1'b1;
            if (v_waddr == 4'hF)
            begin
                vf_next = v_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        flag_reg <= flag_next;
        cnt_reg  <= cnt_next;
        hit_reg  <= hit_next;
        rb_reg   <= rb_next;
        row_reg  <= row_next;
        st_reg   <= st_next;
        v_rq_reg <= v_raddr;
        f_rq_reg <= f_raddr;
        if (stack_we)
        begin
            stack_reg[level_reg[c8x_pkg::SP_BITS-1:0]] <= pc_reg;
        end
        if (res_load)
        begin
            out_reg <= '{pc: pc_reg, index: index_reg, flag: vf_reg, status: st_reg,
                         read_byte: rb_reg, frame_row: row_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= c8x_pkg::S_IDLE;
            pc_reg        <= c8x_pkg::START_ADDRESS_RST;
            index_reg     <= 16'h0000;
            level_reg     <= '0;
            delay_reg     <= 8'h00;
            sound_reg     <= 8'h00;
            vf_reg        <= 8'h00;
            vvalid_reg    <= '0;
            fvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            index_reg     <= index_next;
            level_reg     <= level_next;
            delay_reg     <= delay_next;
            sound_reg     <= sound_next;
            vf_reg        <= vf_next;
            vvalid_reg    <= vvalid_next;
            fvalid_reg    <= fvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_NEVER(a_level_bound, level_reg > c8x_pkg::LVL_BITS'(c8x_pkg::STACK_DEPTH))
    `ASSERT_CLK(a_fill_from_done, $rose(out_valid_reg) |-> $past(state_reg == c8x_pkg::S_DONE))
    `ASSERT_CLK(a_ovf_full, (res_load && st_reg == c8x_pkg::ST_OVF) |-> (level_reg == c8x_pkg::LVL_BITS'(c8x_pkg::STACK_DEPTH)))
    `ASSERT_CLK(a_pop_idle, q_pop |-> (state_reg == c8x_pkg::S_IDLE && q_valid))
endmodule

### sv/chip8_instruction_execute.sv
// Top level of the instruction execute block: front decoder, back sequencer.
// Depends on c8x_pkg, c8x_front and c8x_back.
//
// One request in, one result out, in order. A request is held in the input queue until
// the back end, once idle, takes it. From there the back end steps through its states
// until the result is loaded onto the result ports, S_DONE waiting while one is unpopped:
//   - memory writes: written in S_IDLE, then S_DONE
//   - memory and row reads: S_MRD or S_ROW, then S_DONE
//   - most instructions: S_RDX, S_RDY, S_EXEC, then S_DONE; ALU ops that set VF add S_WRF
//   - a sprite draw: as above, then S_DREQ and S_DDAT per sprite row
//   - register store or load: as above, then S_SRD/S_SWR or S_LRD/S_LWR per register
// The register file and main memory each give one registered byte per read, and the draw,
// store and load walk them one byte at a time, in a read or request state and a write state.
// START_ADDRESS_RST in c8x_pkg is the PC reset value; the config port sets only the font base.
module chip8_instruction_execute (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  req_type,
    input  logic [15:0] instr,
    input  logic [11:0] mem_addr,
    input  logic [7:0]  mem_data,
    input  logic [4:0]  row_select,
    output logic        empty,
    input  logic        pop,
    output logic [11:0] pc_out,
    output logic [15:0] index_out,
    output logic [7:0]  flag_out,
    output logic [1:0]  status,
    output logic [7:0]  read_byte,
    output logic [63:0] frame_row,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    logic             q_valid, q_pop, out_valid;
    c8x_pkg::item_t   q_item;
    c8x_pkg::result_t out_res;
    logic [11:0]      font_base_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_base_reg <= c8x_pkg::FONT_BASE_RST;
        end
        else if (cfg_valid && cfg_index == c8x_pkg::CFG_FONT_BASE)
        begin
            font_base_reg <= cfg_data;
        end
    end

    c8x_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req_type(req_type), .instr(instr), .mem_addr(mem_addr),
        .mem_data(mem_data), .row_select(row_select),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
    );

    c8x_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_pop(q_pop), .font_base(font_base_reg), .out_valid(out_valid),
        .out_res(out_res), .pop(pop)
    );

    assign empty     = !out_valid;
    assign pc_out    = out_res.pc;
    assign index_out = out_res.index;
    assign flag_out  = out_res.flag;
    assign status    = out_res.status;
    assign read_byte = out_res.read_byte;
    assign frame_row = out_res.frame_row;
endmodule
